FILE: hdl/hpced_pkg.sv
// Shared types, constants and register codes of the hot-plug change event detector.
`default_nettype none
package hpced_pkg;

   localparam int GROUPS       = 8;
   localparam int HEALTH_UNITS = 4;
   localparam int QUIET_LIMIT  = 3;

   localparam int GROUP_W = 3;
   localparam int STAT_W  = 8;
   localparam int ENTRY_W = STAT_W + HEALTH_UNITS;
   localparam int MEM_DEPTH = 2 ** GROUP_W;

   localparam logic [1:0] GOOD_HEALTH = 2'h2;

   localparam logic [1:0] KIND_SCAN  = 2'd0;
   localparam logic [1:0] KIND_EVENT = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;

   localparam logic ACT_AGGR  = 1'b0;
   localparam logic ACT_GROUP = 1'b1;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_AGGR_EN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_MASKS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AGGR_BITS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEALTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE    = 3'd4;

   typedef struct packed {
      logic [7:0]  aggr_en;
      logic [63:0] bit_masks;
      logic [63:0] aggr_bits;
      logic [7:0]  health;
      logic [7:0]  inverse;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         kind;
      logic [7:0]         scan;
      logic [GROUP_W-1:0] grp;
      logic [STAT_W-1:0]  pend;
      logic [STAT_W-1:0]  att;
   } load_type;

endpackage
`default_nettype wire

FILE: hdl/hpced_cfg.sv
// Configuration register bank.
`default_nettype none
module hpced_cfg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [hpced_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [63:0]                       csr_wdata,
   output hpced_pkg::cfg_type                     cfg
);

   hpced_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hpced_pkg::CSR_AGGR_EN:   cfg_in.aggr_en   = csr_wdata[7:0];
            hpced_pkg::CSR_BIT_MASKS: cfg_in.bit_masks = csr_wdata;
            hpced_pkg::CSR_AGGR_BITS: cfg_in.aggr_bits = csr_wdata;
            hpced_pkg::CSR_HEALTH:    cfg_in.health    = csr_wdata[7:0];
            hpced_pkg::CSR_INVERSE:   cfg_in.inverse   = csr_wdata[7:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/hpced_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module hpced_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 12,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

FILE: hdl/hpced_emit.sv
// Result serialiser: one pending result or one event per cycle into the output register, unless stalled.
`default_nettype none
module hpced_emit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hpced_pkg::load_type               load,
   output logic                                   busy,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_kind,
   output logic [7:0]                             rsp_scan_groups,
   output logic [hpced_pkg::GROUP_W-1:0]          rsp_event_group,
   output logic [2:0]                             rsp_event_unit,
   output logic                                   rsp_attach,
   output logic                                   rsp_last
);

   logic                          valid_ff, valid_in;
   logic                          single_ff, single_in;
   logic [hpced_pkg::STAT_W-1:0]  pend_ff, pend_in;
   logic [1:0]                    skind_ff, skind_in;
   logic [7:0]                    sscan_ff, sscan_in;
   logic [hpced_pkg::GROUP_W-1:0] grp_ff, grp_in;
   logic [hpced_pkg::STAT_W-1:0]  att_ff, att_in;

   logic [1:0]                    kind_ff, kind_in;
   logic [7:0]                    scan_ff, scan_in;
   logic [hpced_pkg::GROUP_W-1:0] egrp_ff, egrp_in;
   logic [2:0]                    unit_ff, unit_in;
   logic                          attach_ff, attach_in;
   logic                          last_ff, last_in;

   logic [2:0]                    low_idx;
   logic [hpced_pkg::STAT_W-1:0]  pend_rest;
   logic                          out_free;

   assign busy            = valid_ff | single_ff | (|pend_ff);
   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_scan_groups = scan_ff;
   assign rsp_event_group = egrp_ff;
   assign rsp_event_unit  = unit_ff;
   assign rsp_attach      = attach_ff;
   assign rsp_last        = last_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      low_idx = '0;
      for (int b = hpced_pkg::STAT_W - 1; b >= 0; b--) begin
         if (pend_ff[b]) begin
            low_idx = 3'(b);
         end
      end
      pend_rest = pend_ff & ~(hpced_pkg::STAT_W'(1) << low_idx);
   end

   always_comb begin
      valid_in  = valid_ff;
      single_in = single_ff;
      pend_in   = pend_ff;
      skind_in  = skind_ff;
      sscan_in  = sscan_ff;
      grp_in    = grp_ff;
      att_in    = att_ff;
      kind_in   = kind_ff;
      scan_in   = scan_ff;
      egrp_in   = egrp_ff;
      unit_in   = unit_ff;
      attach_in = attach_ff;
      last_in   = last_ff;
      if (load.valid) begin
         if (load.kind == hpced_pkg::KIND_EVENT) begin
            pend_in = load.pend;
         end else begin
            single_in = 1'b1;
         end
         skind_in = load.kind;
         sscan_in = load.scan;
         grp_in   = load.grp;
         att_in   = load.att;
      end else if (out_free) begin
         if (single_ff) begin
            single_in = 1'b0;
            valid_in  = 1'b1;
            kind_in   = skind_ff;
            scan_in   = sscan_ff;
            egrp_in   = '0;
            unit_in   = '0;
            attach_in = 1'b0;
            last_in   = 1'b1;
         end else if (|pend_ff) begin
            pend_in   = pend_rest;
            valid_in  = 1'b1;
            kind_in   = hpced_pkg::KIND_EVENT;
            scan_in   = '0;
            egrp_in   = grp_ff;
            unit_in   = low_idx;
            attach_in = att_ff[low_idx];
            last_in   = ~(|pend_rest);
         end else begin
            valid_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         single_ff <= 1'b0;
         pend_ff   <= '0;
      end else begin
         valid_ff  <= valid_in;
         single_ff <= single_in;
         pend_ff   <= pend_in;
      end
      skind_ff  <= skind_in;
      sscan_ff  <= sscan_in;
      grp_ff    <= grp_in;
      att_ff    <= att_in;
      kind_ff   <= kind_in;
      scan_ff   <= scan_in;
      egrp_ff   <= egrp_in;
      unit_ff   <= unit_in;
      attach_ff <= attach_in;
      last_ff   <= last_in;
   end

endmodule
`default_nettype wire

FILE: hdl/hotplug_change_event_detector.sv
// Hot-plug change event detector top level: sample control, state memory and assertions.
// Takes one sample at a time. An aggregation sample (or a group sample for a group out of
// range) gives its single result through the emitter's pending and output registers; the
// block is free again once that result leaves. A group sample reads its group's entry
// (cached masked status plus attached flags of the health units) from a synchronous memory,
// evaluates it in the next cycle and writes the entry back (in health mode only when the
// masked status changed), then the serial event emitter sends one result per cycle from the
// output register while the output is not stalled: n results per group sample (n is 1 for a
// no-change result, up to 8 events). Output stalls hold the block. Entries are cleared at
// reset through per-entry valid flags, so no clearing pass is needed.
`default_nettype none
module hotplug_change_event_detector (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_action,
   input  wire logic [hpced_pkg::GROUP_W-1:0]     req_group,
   input  wire logic [7:0]                        req_status,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_kind,
   output logic [7:0]                             rsp_scan_groups,
   output logic [hpced_pkg::GROUP_W-1:0]          rsp_event_group,
   output logic [2:0]                             rsp_event_unit,
   output logic                                   rsp_attach,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [hpced_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [63:0]                       csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;
   localparam int   HU      = hpced_pkg::HEALTH_UNITS;
   localparam logic [hpced_pkg::GROUP_W:0] GROUPS_L = (hpced_pkg::GROUP_W + 1)'(hpced_pkg::GROUPS);
   localparam logic [1:0] QUIET_L = 2'(hpced_pkg::QUIET_LIMIT);

   hpced_pkg::cfg_type  cfg;
   hpced_pkg::load_type load;

   logic                                  state_ff, state_in;
   logic [7:0]                            agg_seen_ff, agg_seen_in;
   logic [1:0]                            quiet_ff, quiet_in;
   logic [hpced_pkg::MEM_DEPTH-1:0]       entry_vld_ff, entry_vld_in;
   logic [hpced_pkg::GROUP_W-1:0]         grp_ff;
   logic [7:0]                            status_ff;

   logic                                  emit_busy;
   logic                                  accept;
   logic                                  mem_we;
   logic [hpced_pkg::ENTRY_W-1:0]         mem_wdata;
   logic [hpced_pkg::ENTRY_W-1:0]         mem_rdata;
   logic [hpced_pkg::ENTRY_W-1:0]         entry;
   logic [7:0]                            cache;
   logic [HU-1:0]                         attd;
   logic [HU-1:0]                         new_att;
   logic [7:0]                            bmask;
   logic [7:0]                            masked;
   logic [7:0]                            ev;
   logic [7:0]                            att;
   logic [7:0]                            a_masked;
   logic [7:0]                            a_changed;
   logic [1:0]                            a_quiet;
   logic [7:0]                            a_scan;
   logic                                  good;

   hpced_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   hpced_ram #(
      .DEPTH (hpced_pkg::MEM_DEPTH),
      .WIDTH (hpced_pkg::ENTRY_W),
      .AW    (hpced_pkg::GROUP_W)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (grp_ff),
      .wdata (mem_wdata),
      .re    (accept),
      .raddr (req_group),
      .rdata (mem_rdata)
   );

   hpced_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .busy            (emit_busy),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_scan_groups (rsp_scan_groups),
      .rsp_event_group (rsp_event_group),
      .rsp_event_unit  (rsp_event_unit),
      .rsp_attach      (rsp_attach),
      .rsp_last        (rsp_last)
   );

   assign req_stall = (state_ff != ST_IDLE) || emit_busy;
   assign accept    = req_valid && !req_stall;

   // aggregation sample
   always_comb begin
      a_masked  = req_status & cfg.aggr_en;
      a_changed = a_masked ^ agg_seen_ff;
      a_quiet   = quiet_ff;
      if (quiet_ff == QUIET_L) begin
         a_quiet   = '0;
         a_changed = cfg.aggr_en;
      end
      a_scan = '0;
      for (int k = 0; k < hpced_pkg::GROUPS; k++) begin
         a_scan[k] = |(cfg.aggr_bits[8*k +: 8] & a_changed);
      end
   end

   // group entry evaluation
   always_comb begin
      entry   = entry_vld_ff[grp_ff] ? mem_rdata : '0;
      cache   = entry[7:0];
      attd    = entry[8 +: HU];
      bmask   = cfg.bit_masks[8*grp_ff +: 8];
      masked  = status_ff & bmask;
      ev      = '0;
      att     = '0;
      new_att = attd;
      good    = 1'b0;
      mem_we  = 1'b0;
      if (cfg.health[grp_ff]) begin
         if (masked != cache) begin
            mem_we = 1'b1;
            for (int i = 0; i < HU; i++) begin
               good       = (masked[2*i +: 2] == hpced_pkg::GOOD_HEALTH);
               new_att[i] = good;
               ev[i]      = good ^ attd[i];
               att[i]     = good;
            end
         end
      end else begin
         mem_we = 1'b1;
         ev     = masked ^ cache;
         att    = masked ^ {8{cfg.inverse[grp_ff]}};
      end
      mem_wdata = {new_att, masked};
      if (state_ff != ST_EVAL) begin
         mem_we = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      agg_seen_in   = agg_seen_ff;
      quiet_in      = quiet_ff;
      entry_vld_in  = entry_vld_ff;
      load          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == hpced_pkg::ACT_AGGR) begin
                  agg_seen_in   = a_masked;
                  load.valid    = 1'b1;
                  if (a_changed == '0) begin
                     quiet_in  = a_quiet + 2'd1;
                     load.kind = hpced_pkg::KIND_NONE;
                  end else begin
                     quiet_in  = a_quiet;
                     load.kind = hpced_pkg::KIND_SCAN;
                     load.scan = a_scan;
                  end
               end else if ({1'b0, req_group} >= GROUPS_L) begin
                  load.valid = 1'b1;
                  load.kind  = hpced_pkg::KIND_NONE;
               end else begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            state_in   = ST_IDLE;
            load.valid = 1'b1;
            load.grp   = grp_ff;
            load.pend  = ev;
            load.att   = att;
            load.kind  = (ev != '0) ? hpced_pkg::KIND_EVENT : hpced_pkg::KIND_NONE;
            if (mem_we) begin
               entry_vld_in[grp_ff] = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         agg_seen_ff   <= '0;
         quiet_ff      <= '0;
         entry_vld_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         agg_seen_ff   <= agg_seen_in;
         quiet_ff      <= quiet_in;
         entry_vld_ff  <= entry_vld_in;
      end
      if (accept) begin
         grp_ff    <= req_group;
         status_ff <= req_status;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("block took an item without going busy");

   a_eval_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> !emit_busy)
      else $error("evaluation while results still pending");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != hpced_pkg::KIND_EVENT) |-> rsp_last)
      else $error("single result not marked last");

   a_event_no_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == hpced_pkg::KIND_EVENT) |-> (rsp_scan_groups == '0))
      else $error("event result carries a scan bitmap");

endmodule
`default_nettype wire

FILE: bench/hotplug_change_event_detector_tb.sv
// Self-checking testbench for the hot-plug change event detector: directed table, random samples.
`timescale 1ns / 1ps
module hotplug_change_event_detector_tb;

   localparam int RANDOM_PER_PHASE = 64;
   localparam int PRESSURE_HOLD    = 120;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int DRAIN_CYCLES     = 12;
   localparam int CFG_ROW          = 2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] scan;
      logic [2:0] grp;
      logic [2:0] unit;
      logic       attach;
      logic       last;
   } hp_result_type;

   typedef struct packed {
      logic       act;
      logic [2:0] grp;
      logic [7:0] st;
      logic       typed;
      logic [1:0] kind;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_action = 1'b0;
   logic [2:0] req_group = '0;
   logic [7:0] req_status = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_scan_groups;
   logic [2:0] rsp_event_group;
   logic [2:0] rsp_event_unit;
   logic       rsp_attach;
   logic       rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   // predictor state
   logic [63:0]   csr_shadow [0:4];
   logic [7:0]    agg_seen;
   logic [1:0]    quiet_cnt;
   logic [7:0]    group_cache [0:7];
   bit            unit_attached [0:31];
   hp_result_type predicted [$];
   hp_result_type expected_results [$];

   // stimulus state
   logic [7:0] last_aggr_status;
   logic [7:0] last_group_status [0:7];
   int send_idle_pct;
   int rcv_stall_pct;
   int pressure_requests;
   int pressure_served;
   int hold_left;
   int idle_cycles;

   int mismatches;
   int n_items;
   int n_directed;
   int n_csr_writes;
   int n_settings;
   int n_scan;
   int n_events;
   int n_none;

   stim_row_type directed_rows [0:20] = '{
      '{hpced_pkg::ACT_AGGR,  3'd0, 8'hFF, 1'b1, hpced_pkg::KIND_NONE},
      '{hpced_pkg::ACT_GROUP, 3'd7, 8'hFF, 1'b1, hpced_pkg::KIND_NONE},
      '{hpced_pkg::ACT_AGGR,  3'd0, 8'hFF, 1'b0, hpced_pkg::KIND_SCAN},
      '{hpced_pkg::ACT_AGGR,  3'd0, 8'hFF, 1'b1, hpced_pkg::KIND_NONE},
      '{hpced_pkg::ACT_AGGR,  3'd0, 8'hFF, 1'b1, hpced_pkg::KIND_NONE},
      '{hpced_pkg::ACT_AGGR,  3'd0, 8'hFF, 1'b0, hpced_pkg::KIND_SCAN},
      '{hpced_pkg::ACT_AGGR,  3'd0, 8'hFF, 1'b0, hpced_pkg::KIND_SCAN},
      '{hpced_pkg::ACT_AGGR,  3'd0, 8'h00, 1'b0, hpced_pkg::KIND_SCAN},
      '{hpced_pkg::ACT_GROUP, 3'd0, 8'hFF, 1'b0, hpced_pkg::KIND_EVENT},
      '{hpced_pkg::ACT_GROUP, 3'd0, 8'h00, 1'b0, hpced_pkg::KIND_EVENT},
      '{hpced_pkg::ACT_GROUP, 3'd1, 8'h01, 1'b0, hpced_pkg::KIND_EVENT},
      '{hpced_pkg::ACT_GROUP, 3'd1, 8'h00, 1'b0, hpced_pkg::KIND_EVENT},
      '{hpced_pkg::ACT_GROUP, 3'd2, 8'hAA, 1'b0, hpced_pkg::KIND_EVENT},
      '{hpced_pkg::ACT_GROUP, 3'd2, 8'hAA, 1'b1, hpced_pkg::KIND_NONE},
      '{hpced_pkg::ACT_GROUP, 3'd2, 8'hFF, 1'b0, hpced_pkg::KIND_EVENT},
      '{hpced_pkg::ACT_GROUP, 3'd2, 8'hFE, 1'b0, hpced_pkg::KIND_EVENT},
      '{hpced_pkg::ACT_GROUP, 3'd3, 8'h03, 1'b1, hpced_pkg::KIND_NONE},
      '{hpced_pkg::ACT_GROUP, 3'd5, 8'h80, 1'b0, hpced_pkg::KIND_EVENT},
      '{hpced_pkg::ACT_GROUP, 3'd6, 8'h55, 1'b0, hpced_pkg::KIND_EVENT},
      '{hpced_pkg::ACT_AGGR,  3'd0, 8'h5A, 1'b0, hpced_pkg::KIND_SCAN},
      '{hpced_pkg::ACT_AGGR,  3'd0, 8'h5A, 1'b1, hpced_pkg::KIND_NONE}
   };

   hotplug_change_event_detector u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_group       (req_group),
      .req_status      (req_status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_scan_groups (rsp_scan_groups),
      .rsp_event_group (rsp_event_group),
      .rsp_event_unit  (rsp_event_unit),
      .rsp_attach      (rsp_attach),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void push_predicted(input logic [1:0] kind, input logic [7:0] scan,
                                          input logic [2:0] grp, input logic [2:0] unit,
                                          input logic attach);
      hp_result_type r;
      r.kind = kind;
      r.scan = scan;
      r.grp = grp;
      r.unit = unit;
      r.attach = attach;
      r.last = 1'b0;
      predicted.push_back(r);
   endfunction

   // expected results of one sample; updates the shadow state
   function automatic void predict_sample(input logic act, input logic [2:0] grp,
                                          input logic [7:0] st);
      logic [7:0] masked;
      logic [7:0] changed;
      logic [7:0] scan;
      logic [1:0] field;
      logic       inv;
      int unsigned slot;
      predicted.delete();
      if (act == hpced_pkg::ACT_AGGR) begin
         masked = st & csr_shadow[hpced_pkg::CSR_AGGR_EN][7:0];
         changed = masked ^ agg_seen;
         agg_seen = masked;
         if (quiet_cnt == hpced_pkg::QUIET_LIMIT) begin
            quiet_cnt = '0;
            changed = csr_shadow[hpced_pkg::CSR_AGGR_EN][7:0];
         end
         if (changed == '0) begin
            quiet_cnt = quiet_cnt + 2'd1;
            push_predicted(hpced_pkg::KIND_NONE, '0, '0, '0, 1'b0);
         end else begin
            scan = '0;
            for (int g = 0; g < hpced_pkg::GROUPS; g++)
               if ((csr_shadow[hpced_pkg::CSR_AGGR_BITS][8*g +: 8] & changed) != '0)
                  scan[g] = 1'b1;
            push_predicted(hpced_pkg::KIND_SCAN, scan, '0, '0, 1'b0);
         end
      end else if (grp < hpced_pkg::GROUPS) begin
         masked = st & csr_shadow[hpced_pkg::CSR_BIT_MASKS][8*grp +: 8];
         if (csr_shadow[hpced_pkg::CSR_HEALTH][grp]) begin
            if (masked != group_cache[grp]) begin
               for (int i = 0; i < hpced_pkg::HEALTH_UNITS; i++) begin
                  field = masked[2*i +: 2];
                  slot = grp * 4 + i;
                  if (field == hpced_pkg::GOOD_HEALTH) begin
                     if (!unit_attached[slot]) begin
                        unit_attached[slot] = 1'b1;
                        push_predicted(hpced_pkg::KIND_EVENT, '0, grp, 3'(i), 1'b1);
                     end
                  end else if (unit_attached[slot]) begin
                     unit_attached[slot] = 1'b0;
                     push_predicted(hpced_pkg::KIND_EVENT, '0, grp, 3'(i), 1'b0);
                  end
               end
               group_cache[grp] = masked;
            end
         end else begin
            changed = masked ^ group_cache[grp];
            inv = csr_shadow[hpced_pkg::CSR_INVERSE][grp];
            group_cache[grp] = masked;
            for (int b = 0; b < 8; b++)
               if (changed[b])
                  push_predicted(hpced_pkg::KIND_EVENT, '0, grp, 3'(b), masked[b] ^ inv);
         end
      end
      if (predicted.size() == 0)
         push_predicted(hpced_pkg::KIND_NONE, '0, '0, '0, 1'b0);
      predicted[predicted.size()-1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
      mismatches++;
   endtask

   task automatic offer_sample(input logic act, input logic [2:0] grp, input logic [7:0] st,
                               input logic typed, input logic [1:0] typed_kind);
      hp_result_type r;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_group <= grp;
      req_status <= st;
      do @(posedge clock); while (req_stall);
      predict_sample(act, grp, st);
      if (typed) begin
         r = '0;
         r.kind = typed_kind;
         r.last = 1'b1;
         expected_results.push_back(r);
      end else begin
         foreach (predicted[k])
            expected_results.push_back(predicted[k]);
      end
      n_items++;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_shadow[idx] = data;
      n_csr_writes++;
   endtask

   task automatic load_config(input logic [7:0] en, input logic [63:0] masks,
                              input logic [63:0] aggr_bits, input logic [7:0] health,
                              input logic [7:0] inverse);
      while (expected_results.size() != 0) @(posedge clock);
      write_csr(hpced_pkg::CSR_AGGR_EN, {56'd0, en});
      write_csr(hpced_pkg::CSR_BIT_MASKS, masks);
      write_csr(hpced_pkg::CSR_AGGR_BITS, aggr_bits);
      write_csr(hpced_pkg::CSR_HEALTH, {56'd0, health});
      write_csr(hpced_pkg::CSR_INVERSE, {56'd0, inverse});
      @(negedge clock) csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic run_random_phase(input int count);
      logic       act;
      logic [2:0] grp;
      logic [7:0] st;
      for (int n = 0; n < count; n++) begin
         grp = 3'($urandom_range(7));
         act = ($urandom_range(99) < 25) ? hpced_pkg::ACT_AGGR : hpced_pkg::ACT_GROUP;
         if (act == hpced_pkg::ACT_AGGR) begin
            // repeats build up quiet runs
            st = ($urandom_range(99) < 60) ? last_aggr_status : 8'($urandom);
            last_aggr_status = st;
         end else begin
            if ($urandom_range(4) == 0)
               st = last_group_status[grp];
            else if (csr_shadow[hpced_pkg::CSR_HEALTH][grp]) begin
               for (int i = 0; i < hpced_pkg::HEALTH_UNITS; i++)
                  st[2*i +: 2] = $urandom_range(1) ? hpced_pkg::GOOD_HEALTH : 2'($urandom);
            end else if ($urandom_range(1))
               st = last_group_status[grp] ^ 8'($urandom & $urandom);
            else
               st = 8'($urandom);
            last_group_status[grp] = st;
         end
         offer_sample(act, grp, st, 1'b0, hpced_pkg::KIND_NONE);
      end
      @(negedge clock) req_valid <= 1'b0;
   endtask

   // result side: random stall, long hold-off on request
   always @(negedge clock) begin
      if (pressure_requests != pressure_served) begin
         pressure_served <= pressure_requests;
         hold_left <= PRESSURE_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
   end

   always @(posedge clock) begin : check_results
      hp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         case (rsp_kind)
            hpced_pkg::KIND_SCAN:  n_scan++;
            hpced_pkg::KIND_EVENT: n_events++;
            default:               n_none++;
         endcase
         if (expected_results.size() == 0)
            report_mismatch("item with nothing expected, kind", -1, rsp_kind);
         else begin
            want = expected_results.pop_front();
            if (rsp_kind !== want.kind) report_mismatch("kind", want.kind, rsp_kind);
            if (rsp_scan_groups !== want.scan)
               report_mismatch("scan_groups", want.scan, rsp_scan_groups);
            if (rsp_event_group !== want.grp)
               report_mismatch("event_group", want.grp, rsp_event_group);
            if (rsp_event_unit !== want.unit)
               report_mismatch("event_unit", want.unit, rsp_event_unit);
            if (rsp_attach !== want.attach) report_mismatch("attach", want.attach, rsp_attach);
            if (rsp_last !== want.last) report_mismatch("last", want.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  idle_cycles, expected_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 5; i++) csr_shadow[i] = '0;
      for (int g = 0; g < 8; g++) begin
         group_cache[g] = '0;
         last_group_status[g] = '0;
      end
      foreach (unit_attached[s]) unit_attached[s] = 1'b0;
      agg_seen = '0;
      quiet_cnt = '0;
      last_aggr_status = '0;
      send_idle_pct = 0;
      rcv_stall_pct = 0;
      pressure_requests = 0;
      pressure_served = 0;
      hold_left = 0;
      idle_cycles = 0;
      mismatches = 0;
      n_items = 0;
      n_csr_writes = 0;
      n_settings = 0;
      n_scan = 0;
      n_events = 0;
      n_none = 0;

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: reset values written explicitly first
      send_idle_pct = 10;
      rcv_stall_pct = 30;
      load_config(8'h00, 64'd0, 64'd0, 8'h00, 8'h00);
      foreach (directed_rows[i]) begin
         if (i == CFG_ROW) begin
            @(negedge clock) req_valid <= 1'b0;
            load_config(8'hFF, '1, 64'h8040_2010_0804_0201, 8'h0C, 8'h02);
         end
         offer_sample(directed_rows[i].act, directed_rows[i].grp, directed_rows[i].st,
                      directed_rows[i].typed, directed_rows[i].kind);
      end
      @(negedge clock) req_valid <= 1'b0;
      n_directed = n_items;

      send_idle_pct = 7;
      rcv_stall_pct = 68;
      load_config(8'hFF, '1, '1, 8'hFF, 8'hFF);
      run_random_phase(RANDOM_PER_PHASE);

      send_idle_pct = 68;
      rcv_stall_pct = 7;
      load_config(8'($urandom), {$urandom | $urandom, $urandom | $urandom},
                  {$urandom, $urandom}, 8'($urandom), 8'($urandom));
      run_random_phase(RANDOM_PER_PHASE);

      send_idle_pct = 0;
      rcv_stall_pct = 0;
      load_config(8'($urandom | $urandom), {$urandom | $urandom, $urandom | $urandom},
                  {$urandom, $urandom}, 8'($urandom), 8'($urandom));
      pressure_requests++;
      run_random_phase(RANDOM_PER_PHASE);

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d samples (%0d directed), %0d register writes over %0d settings",
               n_items, n_directed, n_csr_writes, n_settings);
      $display("results: %0d scan, %0d device events, %0d no change; %0d mismatches",
               n_scan, n_events, n_none, mismatches);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hdl/hpced_pkg.sv
hdl/hpced_cfg.sv
hdl/hpced_ram.sv
hdl/hpced_emit.sv
hdl/hotplug_change_event_detector.sv
bench/hotplug_change_event_detector_tb.sv
